[design/sva_pkg.sv]
//------------------------------------------------------------------------------
// sva_pkg: shared types and codes of the 128-bit vector ALU.
// Holds the request and result structs and the operation codes.
//------------------------------------------------------------------------------
`default_nettype none
package sva_pkg;

	localparam logic [4:0] OP_ADD  = 5'd0;
	localparam logic [4:0] OP_SUB  = 5'd1;
	localparam logic [4:0] OP_MUL  = 5'd2;
	localparam logic [4:0] OP_NEG  = 5'd3;
	localparam logic [4:0] OP_MOV  = 5'd4;
	localparam logic [4:0] OP_DUP  = 5'd5;
	localparam logic [4:0] OP_NOT  = 5'd6;
	localparam logic [4:0] OP_AND  = 5'd7;
	localparam logic [4:0] OP_OR   = 5'd8;
	localparam logic [4:0] OP_XOR  = 5'd9;
	localparam logic [4:0] OP_ANDC = 5'd10;
	localparam logic [4:0] OP_ORC  = 5'd11;
	localparam logic [4:0] OP_SHL  = 5'd12;
	localparam logic [4:0] OP_SHR  = 5'd13;
	localparam logic [4:0] OP_SAR  = 5'd14;
	localparam logic [4:0] OP_ZIP  = 5'd15;
	localparam logic [4:0] OP_UZP  = 5'd16;
	localparam logic [4:0] OP_TRN  = 5'd17;
	localparam logic [4:0] OP_EQ   = 5'd18;
	localparam logic [4:0] OP_NE   = 5'd19;
	localparam logic [4:0] OP_LT   = 5'd20;
	localparam logic [4:0] OP_LE   = 5'd21;
	localparam logic [4:0] OP_LTU  = 5'd22;
	localparam logic [4:0] OP_LEU  = 5'd23;
	localparam logic [4:0] OP_EXTU = 5'd24;
	localparam logic [4:0] OP_EXTS = 5'd25;

	localparam logic [1:0] ESZ_8  = 2'd0;
	localparam logic [1:0] ESZ_16 = 2'd1;
	localparam logic [1:0] ESZ_32 = 2'd2;
	localparam logic [1:0] ESZ_64 = 2'd3;

	typedef struct packed {
		logic [4:0]  operation;
		logic [1:0]  element_size;
		logic [63:0] a_low;
		logic [63:0] a_high;
		logic [63:0] b_low;
		logic [63:0] b_high;
		logic [5:0]  immediate;
	} request_t;

	typedef struct packed {
		logic [63:0] d_low;
		logic [63:0] d_high;
		logic        bad_combination;
	} result_t;

	// Operation class decided by the front end.
	localparam logic [2:0] CLS_ARITH = 3'd0;
	localparam logic [2:0] CLS_MUL   = 3'd1;
	localparam logic [2:0] CLS_PERM  = 3'd2;
	localparam logic [2:0] CLS_EXT   = 3'd3;
	localparam logic [2:0] CLS_ZERO  = 3'd4;
	localparam logic [2:0] CLS_BAD   = 3'd5;

	typedef struct packed {
		request_t   req;
		logic [2:0] cls;
	} entry_t;

endpackage
`default_nettype wire

[design/sva_front.sv]
//------------------------------------------------------------------------------
// sva_front: request intake and classification.
// Registers an accepted request together with its operation class.
//------------------------------------------------------------------------------
`default_nettype none
module sva_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              take,
	input  wire sva_pkg::request_t req,
	output sva_pkg::entry_t        ent_s1,
	output logic                   vld_s1
);
	logic [2:0] cls;

	always_comb begin
		unique case (req.operation)
			sva_pkg::OP_MUL: cls = sva_pkg::CLS_MUL;
			sva_pkg::OP_ZIP, sva_pkg::OP_UZP, sva_pkg::OP_TRN: cls = sva_pkg::CLS_PERM;
			sva_pkg::OP_EXTU, sva_pkg::OP_EXTS: begin
				cls = (req.element_size == sva_pkg::ESZ_64) ? sva_pkg::CLS_BAD
				                                            : sva_pkg::CLS_EXT;
			end
			default: begin
				cls = (req.operation <= sva_pkg::OP_LEU) ? sva_pkg::CLS_ARITH
				                                         : sva_pkg::CLS_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s1.req <= req;
			ent_s1.cls <= cls;
		end
	end
endmodule
`default_nettype wire

[design/sva_back.sv]
//------------------------------------------------------------------------------
// sva_back: lane-wise execution.
// Computes the result of one classified request; multiplies are registered
// per lane before the result register.
//------------------------------------------------------------------------------
`default_nettype none
module sva_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            vld_s1,
	input  wire sva_pkg::entry_t ent_s1,
	output logic                 vld_s3,
	output sva_pkg::result_t     res_s3
);
	typedef logic [127:0] vec_t;

	vec_t        a, b, d8, d16, d32, d64, dsel;
	logic [4:0]  op;
	logic [5:0]  imm;
	logic        odd;

	assign a   = {ent_s1.req.a_high, ent_s1.req.a_low};
	assign b   = {ent_s1.req.b_high, ent_s1.req.b_low};
	assign op  = ent_s1.req.operation;
	assign imm = ent_s1.req.immediate;
	assign odd = (imm != 6'd0);

	function automatic logic [63:0] lane_op(input logic [63:0] x, input logic [63:0] y,
		input logic [63:0] s, input logic [4:0] o, input logic [5:0] sh, input logic [6:0] w);
		logic [63:0] m, sb, r, xs, ys;
		logic        big;
		logic [5:0]  sc;
		begin
			m   = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
			sb  = 64'd1 << (w - 7'd1);
			xs  = x ^ sb;
			ys  = y ^ sb;
			big = ({1'b0, sh} >= w);
			sc  = big ? 6'(w - 7'd1) : sh;
			r   = '0;
			case (o)
				sva_pkg::OP_ADD:  r = x + y;
				sva_pkg::OP_SUB:  r = x - y;
				sva_pkg::OP_NEG:  r = 64'd0 - x;
				sva_pkg::OP_MOV:  r = x;
				sva_pkg::OP_DUP:  r = s;
				sva_pkg::OP_NOT:  r = ~x;
				sva_pkg::OP_AND:  r = x & y;
				sva_pkg::OP_OR:   r = x | y;
				sva_pkg::OP_XOR:  r = x ^ y;
				sva_pkg::OP_ANDC: r = x & ~y;
				sva_pkg::OP_ORC:  r = x | ~y;
				sva_pkg::OP_SHL:  r = big ? 64'd0 : (x << sh);
				sva_pkg::OP_SHR:  r = big ? 64'd0 : (x >> sh);
				sva_pkg::OP_SAR:  r = (x >> sc) | (((x & sb) != 0) ? (m & ~(m >> sc)) : 64'd0);
				sva_pkg::OP_EQ:   r = (x == y) ? m : 64'd0;
				sva_pkg::OP_NE:   r = (x != y) ? m : 64'd0;
				sva_pkg::OP_LT:   r = (xs < ys) ? m : 64'd0;
				sva_pkg::OP_LE:   r = (xs <= ys) ? m : 64'd0;
				sva_pkg::OP_LTU:  r = (x < y) ? m : 64'd0;
				sva_pkg::OP_LEU:  r = (x <= y) ? m : 64'd0;
				default:          r = 64'd0;
			endcase
			lane_op = r & m;
		end
	endfunction

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			d8[i*8 +: 8] = 8'(lane_op({56'd0, a[i*8 +: 8]}, {56'd0, b[i*8 +: 8]},
				{56'd0, a[7:0]}, op, imm, 7'd8));
		end
		for (int i = 0; i < 8; i++) begin
			d16[i*16 +: 16] = 16'(lane_op({48'd0, a[i*16 +: 16]}, {48'd0, b[i*16 +: 16]},
				{48'd0, a[15:0]}, op, imm, 7'd16));
		end
		for (int i = 0; i < 4; i++) begin
			d32[i*32 +: 32] = 32'(lane_op({32'd0, a[i*32 +: 32]}, {32'd0, b[i*32 +: 32]},
				{32'd0, a[31:0]}, op, imm, 7'd32));
		end
		for (int i = 0; i < 2; i++) begin
			d64[i*64 +: 64] = lane_op(a[i*64 +: 64], b[i*64 +: 64], a[63:0], op, imm, 7'd64);
		end
	end

	vec_t p8, p16, p32, p64;
	always_comb begin
		p8 = '0; p16 = '0; p32 = '0; p64 = '0;
		case (op)
			sva_pkg::OP_ZIP: begin
				for (int i = 0; i < 8; i++) begin
					p8[(2*i)*8 +: 8] = a[i*8 +: 8]; p8[(2*i+1)*8 +: 8] = b[i*8 +: 8];
				end
				for (int i = 0; i < 4; i++) begin
					p16[(2*i)*16 +: 16] = a[i*16 +: 16]; p16[(2*i+1)*16 +: 16] = b[i*16 +: 16];
				end
				for (int i = 0; i < 2; i++) begin
					p32[(2*i)*32 +: 32] = a[i*32 +: 32]; p32[(2*i+1)*32 +: 32] = b[i*32 +: 32];
				end
				p64 = {b[63:0], a[63:0]};
			end
			sva_pkg::OP_UZP: begin
				for (int i = 0; i < 8; i++) begin
					p8[i*8 +: 8]     = a[(2*i+odd)*8 +: 8];
					p8[(8+i)*8 +: 8] = b[(2*i+odd)*8 +: 8];
				end
				for (int i = 0; i < 4; i++) begin
					p16[i*16 +: 16]     = a[(2*i+odd)*16 +: 16];
					p16[(4+i)*16 +: 16] = b[(2*i+odd)*16 +: 16];
				end
				for (int i = 0; i < 2; i++) begin
					p32[i*32 +: 32]     = a[(2*i+odd)*32 +: 32];
					p32[(2+i)*32 +: 32] = b[(2*i+odd)*32 +: 32];
				end
				p64 = odd ? {b[127:64], a[127:64]} : {b[63:0], a[63:0]};
			end
			sva_pkg::OP_TRN: begin
				for (int i = 0; i < 8; i++) begin
					p8[(2*i)*8 +: 8]   = a[(2*i+odd)*8 +: 8];
					p8[(2*i+1)*8 +: 8] = b[(2*i+odd)*8 +: 8];
				end
				for (int i = 0; i < 4; i++) begin
					p16[(2*i)*16 +: 16]   = a[(2*i+odd)*16 +: 16];
					p16[(2*i+1)*16 +: 16] = b[(2*i+odd)*16 +: 16];
				end
				for (int i = 0; i < 2; i++) begin
					p32[(2*i)*32 +: 32]   = a[(2*i+odd)*32 +: 32];
					p32[(2*i+1)*32 +: 32] = b[(2*i+odd)*32 +: 32];
				end
				p64 = odd ? {b[127:64], a[127:64]} : {b[63:0], a[63:0]};
			end
			sva_pkg::OP_EXTU, sva_pkg::OP_EXTS: begin
				for (int i = 0; i < 8; i++) begin
					p8[i*16 +: 16] = {{8{(op == sva_pkg::OP_EXTS) & a[i*8+7]}}, a[i*8 +: 8]};
				end
				for (int i = 0; i < 4; i++) begin
					p16[i*32 +: 32] = {{16{(op == sva_pkg::OP_EXTS) & a[i*16+15]}},
						a[i*16 +: 16]};
				end
				for (int i = 0; i < 2; i++) begin
					p32[i*64 +: 64] = {{32{(op == sva_pkg::OP_EXTS) & a[i*32+31]}},
						a[i*32 +: 32]};
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		unique case (ent_s1.req.element_size)
			sva_pkg::ESZ_8:  dsel = (ent_s1.cls == sva_pkg::CLS_ARITH) ? d8  : p8;
			sva_pkg::ESZ_16: dsel = (ent_s1.cls == sva_pkg::CLS_ARITH) ? d16 : p16;
			sva_pkg::ESZ_32: dsel = (ent_s1.cls == sva_pkg::CLS_ARITH) ? d32 : p32;
			default:         dsel = (ent_s1.cls == sva_pkg::CLS_ARITH) ? d64 : p64;
		endcase
		if (ent_s1.cls == sva_pkg::CLS_ZERO || ent_s1.cls == sva_pkg::CLS_BAD
			|| ent_s1.cls == sva_pkg::CLS_MUL) begin
			dsel = '0;
		end
	end

	// Stage 2: direct result, lane products and raw 32x32 partial products.
	logic        ismul_s2, bad_s2;
	logic [1:0]  esz_s2;
	vec_t        dir_s2, m8_s2, m16_s2, m32_s2;
	logic [63:0] ll_s2 [2];
	logic [63:0] lh_s2 [2];
	logic [63:0] hl_s2 [2];

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			dir_s2   <= dsel;
			ismul_s2 <= (ent_s1.cls == sva_pkg::CLS_MUL);
			bad_s2   <= (ent_s1.cls == sva_pkg::CLS_BAD);
			esz_s2   <= ent_s1.req.element_size;
			for (int i = 0; i < 16; i++) begin
				m8_s2[i*8 +: 8] <= 8'(a[i*8 +: 8] * b[i*8 +: 8]);
			end
			for (int i = 0; i < 8; i++) begin
				m16_s2[i*16 +: 16] <= 16'(a[i*16 +: 16] * b[i*16 +: 16]);
			end
			for (int i = 0; i < 4; i++) begin
				m32_s2[i*32 +: 32] <= 32'(a[i*32 +: 32] * b[i*32 +: 32]);
			end
			for (int i = 0; i < 2; i++) begin
				ll_s2[i] <= 64'(a[i*64 +: 32] * b[i*64 +: 32]);
				lh_s2[i] <= 64'(a[i*64 +: 32] * b[i*64+32 +: 32]);
				hl_s2[i] <= 64'(a[i*64+32 +: 32] * b[i*64 +: 32]);
			end
		end
	end

	logic  vld_s2;
	vec_t  m64;
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			m64[i*64 +: 64] = ll_s2[i] + {lh_s2[i][31:0] + hl_s2[i][31:0], 32'd0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			res_s3.bad_combination <= bad_s2;
			if (ismul_s2) begin
				unique case (esz_s2)
					sva_pkg::ESZ_8:  {res_s3.d_high, res_s3.d_low} <= m8_s2;
					sva_pkg::ESZ_16: {res_s3.d_high, res_s3.d_low} <= m16_s2;
					sva_pkg::ESZ_32: {res_s3.d_high, res_s3.d_low} <= m32_s2;
					default:         {res_s3.d_high, res_s3.d_low} <= m64;
				endcase
			end else begin
				{res_s3.d_high, res_s3.d_low} <= dir_s2;
			end
		end
	end
endmodule
`default_nettype wire

[design/simd_vector_alu_128.sv]
//------------------------------------------------------------------------------
// simd_vector_alu_128: 128-bit SIMD vector ALU with three register stages.
// done follows an accepted request through the valid registers vld_s1, vld_s2 and vld_s3.
// Throughput: one request every cycle; busy stays low, as results cannot be held off.
// Reset clears all valid flags; no result strobe follows reset until a request.
//------------------------------------------------------------------------------
`default_nettype none
module simd_vector_alu_128 (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire sva_pkg::request_t request,
	output logic                   done,
	output sva_pkg::result_t       result
);
	sva_pkg::entry_t ent_s1;
	logic            vld_s1;

	assign busy = 1'b0;

	sva_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (start & ~busy),
		.req    (request),
		.ent_s1 (ent_s1),
		.vld_s1 (vld_s1)
	);

	sva_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_s1 (vld_s1),
		.ent_s1 (ent_s1),
		.vld_s3 (done),
		.res_s3 (result)
	);
endmodule
`default_nettype wire

[design/sva_checker.sv]
//------------------------------------------------------------------------------
// sva_checker: port-level checks of the vector ALU.
// Checks strobe timing against accepted requests and that flagged results are zero.
//------------------------------------------------------------------------------
`default_nettype none
module sva_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire sva_pkg::result_t result
);
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done) else $error("missing result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 3)) else $error("spurious result");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.bad_combination) |-> (result.d_low == 64'd0 && result.d_high == 64'd0))
		else $error("flagged result not zero");
endmodule

bind simd_vector_alu_128 sva_checker u_sva_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);
`default_nettype wire
